@@ hw/rtl/uri_percent_decoder_macros.svh @@
// Assertion macros used by the decoder RTL.
`ifndef URI_PERCENT_DECODER_MACROS_SVH
`define URI_PERCENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/upd_pkg.sv @@
package upd_pkg;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } t_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_DIGIT = 2'd1;
    localparam logic [1:0] ST_ONE_DIG  = 2'd2;
    localparam logic [1:0] ST_BAD_HEX  = 2'd3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] high_char;
        logic       in_query;
        logic       dropping;
    } t_state;

    localparam t_state STATE_IDLE = '{phase: PH_PLAIN, high_char: 8'h00,
                                      in_query: 1'b0, dropping: 1'b0};

    typedef struct packed {
        logic       vld;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       eos;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'h0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.val = 4'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            h.val = 4'(c - CH_UP_A + HEX_TEN);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            h.val = 4'(c - CH_LO_A + HEX_TEN);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ hw/rtl/uri_percent_decoder.sv @@
// Streaming URI percent-decoder. Raw bytes of an encoded string enter one byte
// per cycle while o_in_ready is high, with i_last_of_string marking the final
// byte. A '%' followed by two hex digits of either case gives one decoded byte,
// and after a raw '?' a '+' decodes to a space when the plus-to-space register
// (APB address 0, bit 0) is set. A percent sequence gives no word until its
// low digit arrives. Errors come out as one word with a nonzero o_status and
// o_end_of_string set: 1 for a percent on the last byte, 2 for a single digit
// before the end, 3 for a non-hex digit (checked once both digits are in).
// After an error the rest of the string is dropped without output through its
// last byte. Each byte passes through an input register and a result register
// with combinational decode logic between them, so the block sustains one byte
// per cycle while the output is taken; o_out_valid rises once the byte that
// completes a word has passed both registers. The input side keeps accepting
// while a finished word waits at the output, and stalls only when both
// registers are full.
`include "uri_percent_decoder_macros.svh"

module uri_percent_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_of_string,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_end_of_string,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration register. Only address bit 2 is decoded: it picks the
    // register, and the low two bits are ignored.
    logic r_plus_space;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_plus_space} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_space <= 1'b0;
        end else if (cfg_wr && paddr[2] == 1'b0) begin
            r_plus_space <= pwdata[0];
        end
    end

    // Input register stage.
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state, advanced once per byte taken from the input register.
    upd_pkg::t_state  r_state;
    upd_pkg::t_state  n_state;
    upd_pkg::t_result step_res;

    // Result register.
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic [1:0] r_out_status;
    logic       r_out_eos;

    logic fire;

    // A byte leaves the input register when the result register is free or
    // is being emptied in this cycle.
    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    upd_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_plus_space (r_plus_space),
        .o_state      (n_state),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= upd_pkg::STATE_IDLE;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && step_res.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_res.vld) begin
            r_out_byte   <= step_res.out_byte;
            r_out_status <= step_res.status;
            r_out_eos    <= step_res.eos;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_byte      = r_out_byte;
    assign o_status        = r_out_status;
    assign o_end_of_string = r_out_eos;

    // Terms used by the checks below.
    logic err_out;
    logic err_shape;
    logic drop_fire;
    logic last_fire;
    logic word_fire;
    logic st_idle;

    assign err_out   = r_out_vld && r_out_status != upd_pkg::ST_OK;
    assign err_shape = r_out_eos && r_out_byte == 8'h00;
    assign drop_fire = fire && r_state.dropping;
    assign last_fire = fire && r_in_last;
    assign word_fire = fire && step_res.vld;
    assign st_idle   = (r_state == upd_pkg::STATE_IDLE);

    // An error word always closes the string and carries a zero byte.
    `UPD_ASSERT_NOW(a_err_closes, i_clk, i_rst_n, err_out, err_shape, "error word without eos")

    // Nothing is produced while the rest of a failed string is skipped.
    `UPD_ASSERT_NOW(a_drop_silent, i_clk, i_rst_n, drop_fire, !step_res.vld, "word while dropping")

    // The last byte of a string returns the decoder to its idle state.
    `UPD_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, last_fire, st_idle, "state not cleared")

    // A decoded word reaches the output register in the following cycle.
    `UPD_ASSERT_NEXT(a_word_lands, i_clk, i_rst_n, word_fire, o_out_valid, "decoded word lost")

endmodule

@@ hw/rtl/upd_step.sv @@
// Next-state and result logic for one raw byte.
module upd_step (
    input  upd_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_plus_space,
    output upd_pkg::t_state  o_state,
    output upd_pkg::t_result o_result
);

    upd_pkg::t_hex hv;
    upd_pkg::t_hex lv;
    logic          query_now;

    assign hv        = upd_pkg::hex_value(i_state.high_char);
    assign lv        = upd_pkg::hex_value(i_byte);
    assign query_now = i_state.in_query | (i_byte == upd_pkg::CH_QUEST);

    always_comb begin
        o_state  = i_state;
        o_result = '{vld: 1'b0, out_byte: 8'h00, status: upd_pkg::ST_OK, eos: 1'b0};

        if (i_state.dropping) begin
            if (i_last) begin
                o_state = upd_pkg::STATE_IDLE;
            end
        end else begin
            case (i_state.phase)
                upd_pkg::PH_HIGH: begin
                    if (i_last) begin
                        o_state  = upd_pkg::STATE_IDLE;
                        o_result = '{vld: 1'b1, out_byte: 8'h00,
                                     status: upd_pkg::ST_ONE_DIG, eos: 1'b1};
                    end else begin
                        o_state.high_char = i_byte;
                        o_state.phase     = upd_pkg::PH_LOW;
                    end
                end
                upd_pkg::PH_LOW: begin
                    o_state.phase     = upd_pkg::PH_PLAIN;
                    o_state.high_char = 8'h00;
                    if (!hv.ok || !lv.ok) begin
                        o_state.dropping = !i_last;
                        o_result = '{vld: 1'b1, out_byte: 8'h00,
                                     status: upd_pkg::ST_BAD_HEX, eos: 1'b1};
                    end else begin
                        o_result = '{vld: 1'b1, out_byte: {hv.val, lv.val},
                                     status: upd_pkg::ST_OK, eos: i_last};
                    end
                    if (i_last) begin
                        o_state = upd_pkg::STATE_IDLE;
                    end
                end
                default: begin
                    o_state.in_query = query_now;
                    if (query_now && i_plus_space && i_byte == upd_pkg::CH_PLUS) begin
                        o_result = '{vld: 1'b1, out_byte: upd_pkg::CH_SPACE,
                                     status: upd_pkg::ST_OK, eos: i_last};
                    end else if (i_byte == upd_pkg::CH_PERCENT) begin
                        if (i_last) begin
                            o_result = '{vld: 1'b1, out_byte: 8'h00,
                                         status: upd_pkg::ST_NO_DIGIT, eos: 1'b1};
                        end else begin
                            o_state.phase = upd_pkg::PH_HIGH;
                        end
                    end else begin
                        o_result = '{vld: 1'b1, out_byte: i_byte,
                                     status: upd_pkg::ST_OK, eos: i_last};
                    end
                    if (i_last) begin
                        o_state = upd_pkg::STATE_IDLE;
                    end
                end
            endcase
        end
    end

endmodule
